// File: rtl/jlsp_pkg.sv
// Shared types and constants for the jerk-limited speed profile core.
`default_nettype none

package jlsp_pkg;

   // Field widths fixed by the Q8.8 / Q0.16 / Q16.16 formats.
   localparam int SPEED_W = 16;
   localparam int ACCEL_W = 16;
   localparam int LIMIT_W = 15;
   localparam int STEP_W  = 16;
   localparam int DIST_W  = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_CAP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_JERK_LIMIT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP   = 2'd3;

   // Register values after reset.
   localparam logic [SPEED_W-1:0] SPEED_CAP_RESET   = 16'd5632;
   localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RESET = 15'd2304;
   localparam logic [LIMIT_W-1:0] JERK_LIMIT_RESET  = 15'd2304;
   localparam logic [STEP_W-1:0]  TIME_STEP_RESET   = 16'd1311;

   // Speed error of 0.1 m/s in Q8.8 units.
   localparam logic signed [SPEED_W:0] DEADBAND = 17'sd26;

   // Operand pair for the shared multiplier.
   typedef enum logic [1:0] {
      MUL_JERK,
      MUL_ACCEL,
      MUL_SPEED
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;        // request accepted: latch target, maybe load state
      logic        upd_accel;   // write the ramped acceleration
      logic        upd_speed;   // write the integrated, clamped speed
      logic        upd_dist;    // write distance and the response registers
      mul_sel_type mul_sel;
   } dp_cmd_type;

endpackage

`default_nettype wire

// File: rtl/jlsp_ctrl.sv
// Step sequencer and response-valid control for the speed profile core.
`default_nettype none

module jlsp_ctrl
   import jlsp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCEL,
      ST_VEL_MUL,
      ST_SPEED,
      ST_DIST_MUL,
      ST_DIST
   } state_type;

   state_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish;

   // The last step may only write the response registers once they are free.
   assign finish = (phase_ff == ST_DIST) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (phase_ff)
         ST_IDLE:     if (req_valid) phase_in = ST_ACCEL;
         ST_ACCEL:    phase_in = ST_VEL_MUL;
         ST_VEL_MUL:  phase_in = ST_SPEED;
         ST_SPEED:    phase_in = ST_DIST_MUL;
         ST_DIST_MUL: phase_in = ST_DIST;
         ST_DIST: begin
            if (finish) begin
               phase_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:     phase_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (phase_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load      = (phase_ff == ST_IDLE) && req_valid;
      cmd.upd_accel = (phase_ff == ST_ACCEL);
      cmd.upd_speed = (phase_ff == ST_SPEED);
      cmd.upd_dist  = finish;
      unique case (phase_ff)
         ST_VEL_MUL:           cmd.mul_sel = MUL_ACCEL;
         ST_DIST_MUL, ST_DIST: cmd.mul_sel = MUL_SPEED;
         default:              cmd.mul_sel = MUL_JERK;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/jlsp_datapath.sv
// Configuration registers, profile state, shared multiplier and step arithmetic.
`default_nettype none

module jlsp_datapath
   import jlsp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data,
   input  wire logic                      req_cmd,
   input  wire logic [SPEED_W-1:0]        req_target_speed,
   input  wire logic [SPEED_W-1:0]        req_init_speed,
   input  wire logic signed [ACCEL_W-1:0] req_init_accel,
   output logic [SPEED_W-1:0]             rsp_speed,
   output logic signed [ACCEL_W-1:0]      rsp_accel,
   output logic [DIST_W-1:0]              rsp_distance
);

   logic [SPEED_W-1:0] speed_cap_ff;
   logic [LIMIT_W-1:0] accel_limit_ff;
   logic [LIMIT_W-1:0] jerk_limit_ff;
   logic [STEP_W-1:0]  time_step_ff;

   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic signed [ACCEL_W-1:0] accel_ff, accel_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic [SPEED_W-1:0]        target_ff;

   logic signed [SPEED_W:0]   mul_a, mul_b;
   logic signed [2*SPEED_W+1:0] prod_ff, prod_in;

   logic [LIMIT_W-1:0]        jstep;
   logic signed [SPEED_W:0]   err;
   logic [SPEED_W:0]          err_abs;
   logic [SPEED_W+3:0]        err_x10;
   logic                      near;
   logic signed [17:0]        a_x, j_x, amax_x, a_next;

   logic signed [17:0]        vinc;
   logic signed [18:0]        sp_sum;
   logic [DIST_W:0]           dist_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cap_ff   <= SPEED_CAP_RESET;
         accel_limit_ff <= ACCEL_LIMIT_RESET;
         jerk_limit_ff  <= JERK_LIMIT_RESET;
         time_step_ff   <= TIME_STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SPEED_CAP:   speed_cap_ff   <= csr_data;
            CSR_ACCEL_LIMIT: accel_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_JERK_LIMIT:  jerk_limit_ff  <= csr_data[LIMIT_W-1:0];
            CSR_TIME_STEP:   time_step_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // One 17x17 signed multiplier, shared by the three products of a step.
   always_comb begin
      mul_b = $signed({1'b0, time_step_ff});
      unique case (cmd.mul_sel)
         MUL_JERK:  mul_a = $signed({2'b00, jerk_limit_ff});
         MUL_ACCEL: mul_a = $signed({accel_ff[ACCEL_W-1], accel_ff});
         MUL_SPEED: mul_a = $signed({1'b0, speed_ff});
         default:   mul_a = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Acceleration ramp. The jerk product is nonnegative and below 2^31.
   assign jstep   = prod_ff[30:16];
   assign err     = $signed({1'b0, target_ff}) - $signed({1'b0, speed_ff});
   assign err_abs = err[SPEED_W] ? 17'(-err) : 17'(err);
   assign err_x10 = ({3'b000, err_abs} << 3) + ({3'b000, err_abs} << 1);
   assign near    = err_x10 < {4'b0000, target_ff};
   assign a_x     = 18'(accel_ff);
   assign j_x     = $signed({3'b000, jstep});
   assign amax_x  = $signed({3'b000, accel_limit_ff});

   always_comb begin
      a_next = a_x;
      if (err >= DEADBAND) begin
         if (near) a_next = (a_x >= j_x) ? a_x - j_x : '0;
         else      a_next = (a_x >= amax_x - j_x) ? amax_x : a_x + j_x;
      end else if (err <= -DEADBAND) begin
         if (near) a_next = (a_x <= -j_x) ? a_x + j_x : '0;
         else      a_next = (a_x <= j_x - amax_x) ? -amax_x : a_x - j_x;
      end
   end

   // Speed integration: the arithmetic shift floors toward minus infinity.
   assign vinc   = prod_ff[33:16];
   assign sp_sum = $signed({3'b000, speed_ff}) + 19'(vinc);

   // Distance integration with saturation.
   assign dist_sum = {1'b0, dist_ff} + {9'd0, prod_ff[31:8]};

   always_comb begin
      speed_in = speed_ff;
      accel_in = accel_ff;
      dist_in  = dist_ff;
      if (cmd.load) begin
         if (req_cmd) begin
            speed_in = req_init_speed;
            accel_in = req_init_accel;
            dist_in  = '0;
         end
      end else if (cmd.upd_accel) begin
         accel_in = a_next[ACCEL_W-1:0];
      end else if (cmd.upd_speed) begin
         if (sp_sum >= $signed({3'b000, speed_cap_ff})) begin
            speed_in = speed_cap_ff;
         end else if (sp_sum < 0) begin
            speed_in = '0;
         end else begin
            speed_in = sp_sum[SPEED_W-1:0];
         end
      end else if (cmd.upd_dist) begin
         dist_in = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         accel_ff <= '0;
         dist_ff  <= '0;
      end else begin
         speed_ff <= speed_in;
         accel_ff <= accel_in;
         dist_ff  <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= req_target_speed;
      end
      if (cmd.upd_dist) begin
         rsp_speed    <= speed_ff;
         rsp_accel    <= accel_ff;
         rsp_distance <= dist_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/jerk_limited_speed_profile_core.sv
// Top level of the jerk-limited speed profile core: controller, datapath and checks.
//
// Each request advances the profile by one time step and yields exactly one
// response with the new speed (Q8.8), acceleration (signed Q8.8) and the
// distance travelled since the last load (Q16.16, saturating).
// A request with req_cmd set first loads req_init_speed and req_init_accel
// and clears the distance, then steps as usual.
// Both channels move a request when valid is high and stall is low.
// The core takes one request at a time: req_stall is low only while idle.
// A request passes the acceleration, velocity product, speed, distance
// product and distance steps, and only after its response is written can
// the next be accepted. One shared 17x17 multiplier forms the jerk step,
// the speed increment and the distance increment in turn, each product
// registered before the adder and clamp logic that uses it.
// A finished response sits in an output register; while the receiver stalls
// it holds, and the core still accepts and works on the next request, only
// waiting in its last step until the output register is free.
// Configuration registers are written through csr_write, csr_index and csr_data;
// the user must do so only while the core is idle; the core does not enforce it.
// Reset restores the register defaults and zeroes speed, acceleration and distance.
`default_nettype none

module jerk_limited_speed_profile_core
   import jlsp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_cmd,
   input  wire logic [SPEED_W-1:0]        req_target_speed,
   input  wire logic [SPEED_W-1:0]        req_init_speed,
   input  wire logic signed [ACCEL_W-1:0] req_init_accel,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [SPEED_W-1:0]             rsp_speed,
   output logic signed [ACCEL_W-1:0]      rsp_accel,
   output logic [DIST_W-1:0]              rsp_distance
);

   dp_cmd_type cmd;

   // The controller sequences the five work steps of a request.
   jlsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the profile state and the arithmetic.
   jlsp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_cmd          (req_cmd),
      .req_target_speed (req_target_speed),
      .req_init_speed   (req_init_speed),
      .req_init_accel   (req_init_accel),
      .rsp_speed        (rsp_speed),
      .rsp_accel        (rsp_accel),
      .rsp_distance     (rsp_distance)
   );

   // An accepted request keeps the core busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core not busy after accepting a request");

   // A new response only appears as the last step of a request completes.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a request in progress");

   // After a response is taken, valid stays only if a new one was written.
   a_rsp_refill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid || $past(req_stall))
      else $error("response repeated after it was taken");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the jerk-limited speed profile core.
`timescale 1ns / 100ps

module tb_top
   import jlsp_pkg::*;
();

   // One profile point as the core reports it.
   typedef struct packed {
      logic [SPEED_W-1:0]        speed;
      logic signed [ACCEL_W-1:0] accel;
      logic [DIST_W-1:0]         distance;
   } profile_point_type;

   // The scoreboard keeps its own copy of the registers and of the profile
   // state. Every accepted request advances that state by one time step and
   // queues the point the core must report; responses are matched in order.
   class speed_profile_scoreboard_type;
      logic [SPEED_W-1:0]        cap = SPEED_CAP_RESET;
      logic [LIMIT_W-1:0]        amax = ACCEL_LIMIT_RESET;
      logic [LIMIT_W-1:0]        jerk = JERK_LIMIT_RESET;
      logic [STEP_W-1:0]         dt = TIME_STEP_RESET;
      logic [SPEED_W-1:0]        cur_speed = '0;
      logic signed [ACCEL_W-1:0] cur_accel = '0;
      logic [DIST_W-1:0]         travelled = '0;
      profile_point_type         expected_points[$];
      int                        mismatches = 0;

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SPEED_CAP:   cap = data;
            CSR_ACCEL_LIMIT: amax = data[LIMIT_W-1:0];
            CSR_JERK_LIMIT:  jerk = data[LIMIT_W-1:0];
            CSR_TIME_STEP:   dt = data;
            default: ;
         endcase
      endfunction

      function void note_request(logic cmd, logic [SPEED_W-1:0] target,
                                 logic [SPEED_W-1:0] init_speed,
                                 logic signed [ACCEL_W-1:0] init_accel);
         longint j, a, am, err, mag, db, sp, sum;
         bit near;
         profile_point_type pt;
         if (cmd) begin
            cur_speed = init_speed;
            cur_accel = init_accel;
            travelled = '0;
         end
         j = (longint'(jerk) * longint'(dt)) >> 16;
         am = longint'(amax);
         db = longint'(DEADBAND);
         a = longint'(cur_accel);
         err = longint'(target) - longint'(cur_speed);
         mag = (err < 0) ? -err : err;
         near = (mag * 10) < longint'(target);
         // Outside the deadband the acceleration ramps by one jerk step,
         // toward the limit when far from the target and toward zero when near.
         if (err >= db) begin
            if (near)
               a = (a >= j) ? a - j : 0;
            else
               a = (a >= am - j) ? am : a + j;
         end else if (err <= -db) begin
            if (near)
               a = (a <= -j) ? a + j : 0;
            else
               a = (a <= j - am) ? -am : a - j;
         end
         cur_accel = a[ACCEL_W-1:0];
         // The speed increment rounds toward minus infinity.
         sp = longint'(cur_speed) + ((a * longint'(dt)) >>> 16);
         if (sp >= longint'(cap))
            sp = longint'(cap);
         if (sp < 0)
            sp = 0;
         cur_speed = sp[SPEED_W-1:0];
         sum = longint'(travelled) + ((longint'(cur_speed) * longint'(dt)) >> 8);
         if (sum > 64'h0000_0000_FFFF_FFFF)
            travelled = '1;
         else
            travelled = sum[DIST_W-1:0];
         pt.speed = cur_speed;
         pt.accel = cur_accel;
         pt.distance = travelled;
         expected_points.insert(expected_points.size(), pt);
      endfunction

      function void check_response(logic [SPEED_W-1:0] speed,
                                   logic signed [ACCEL_W-1:0] accel,
                                   logic [DIST_W-1:0] distance);
         profile_point_type pt;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no request outstanding: ",
                        "speed %0d accel %0d distance %0d",
                        $realtime, speed, accel, distance);
            return;
         end
         pt = expected_points.pop_front();
         if (speed !== pt.speed || accel !== pt.accel || distance !== pt.distance) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: speed exp %0d got %0d, accel exp %0d got %0d, ",
                        "distance exp %0d got %0d",
                        $realtime, pt.speed, speed, pt.accel, accel, pt.distance, distance);
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function bit failed();
         return mismatches != 0 || expected_points.size() != 0;
      endfunction
   endclass

   // Clock, reset and every input start from known values.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_SPEED_CAP;
   logic [CSR_DATA_W-1:0]     csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = 1'b0;
   logic [SPEED_W-1:0]        req_target_speed = '0;
   logic [SPEED_W-1:0]        req_init_speed = '0;
   logic signed [ACCEL_W-1:0] req_init_accel = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SPEED_W-1:0]        rsp_speed;
   logic signed [ACCEL_W-1:0] rsp_accel;
   logic [DIST_W-1:0]         rsp_distance;

   // Percent of cycles in which the sender idles and the receiver stalls.
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   speed_profile_scoreboard_type sb = new();

   jerk_limited_speed_profile_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_target_speed (req_target_speed),
      .req_init_speed   (req_init_speed),
      .req_init_accel   (req_init_accel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_speed        (rsp_speed),
      .rsp_accel        (rsp_accel),
      .rsp_distance     (rsp_distance)
   );

   always #1 clock = ~clock;

   // Response side: at each rising edge the values seen are the ones that
   // were present at the edge, so a response counts as taken exactly when
   // valid was high and our stall was low. The stall for the next cycle is
   // drawn in the same block.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_speed, rsp_accel, rsp_distance);
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   // Presents one request and returns at the edge where it was taken. The
   // sender may idle first; valid is only lowered when a gap is taken, so a
   // back-to-back request keeps valid high with no glitch.
   task automatic send_request(input logic cmd, input logic [SPEED_W-1:0] target,
                               input logic [SPEED_W-1:0] init_speed,
                               input logic signed [ACCEL_W-1:0] init_accel);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_target_speed <= target;
      req_init_speed <= init_speed;
      req_init_accel <= init_accel;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(cmd, target, init_speed, init_accel);
   endtask

   // Holds the sender off until every outstanding request has answered.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      sb.write_reg(index, data);
      @(posedge clock);
   endtask

   // Writes all four registers back to back; only called with the core idle.
   task automatic configure(input logic [CSR_DATA_W-1:0] cap,
                            input logic [CSR_DATA_W-1:0] accel_lim,
                            input logic [CSR_DATA_W-1:0] jerk_lim,
                            input logic [CSR_DATA_W-1:0] step);
      write_reg(CSR_SPEED_CAP, cap);
      write_reg(CSR_ACCEL_LIMIT, accel_lim);
      write_reg(CSR_JERK_LIMIT, jerk_lim);
      write_reg(CSR_TIME_STEP, step);
      csr_write <= 1'b0;
   endtask

   // Picks a register value at the low end, the high end, or in between.
   function automatic logic [CSR_DATA_W-1:0] pick_extreme(input int lo, input int hi);
      case ($urandom_range(0, 2))
         0: return CSR_DATA_W'(lo);
         1: return CSR_DATA_W'(hi);
         default: return CSR_DATA_W'($urandom_range(lo, hi));
      endcase
   endfunction

   // Target speeds are drawn so that the deadband, the near band and the far
   // ramp all see plenty of traffic: some land right around the predicted
   // current speed, some at zero, some just under the speed ceiling.
   function automatic logic [SPEED_W-1:0] pick_target();
      int t;
      case ($urandom_range(0, 4))
         0: t = int'($urandom_range(0, 65535));
         1: t = 0;
         2: t = int'(sb.cur_speed) + int'($urandom_range(0, 80)) - 40;
         3: t = int'(sb.cap) - int'($urandom_range(0, 300));
         default: t = int'($urandom_range(0, int'(sb.cap)));
      endcase
      if (t < 0)
         t = 0;
      if (t > 65535)
         t = 65535;
      return SPEED_W'(t);
   endfunction

   // Random traffic shaped as profile runs: a load request followed by a run
   // of plain steps toward a target that now and then moves. A minority of
   // requests carry a random command bit, which breaks runs at odd places.
   task automatic run_random(input int count);
      int run_left;
      int r;
      logic cmd;
      logic [SPEED_W-1:0] target;
      logic [SPEED_W-1:0] init_speed;
      logic signed [ACCEL_W-1:0] init_accel;
      run_left = 0;
      target = pick_target();
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         init_speed = SPEED_W'($urandom());
         init_accel = ACCEL_W'($urandom());
         if (run_left == 0 || r < 8) begin
            cmd = 1'b1;
            run_left = $urandom_range(3, 20);
            if ($urandom_range(0, 1))
               init_speed = SPEED_W'($urandom_range(0, int'(sb.cap)));
            if ($urandom_range(0, 1))
               init_accel = ACCEL_W'(int'($urandom_range(0, 1200)) - 600);
            target = pick_target();
         end else begin
            cmd = (r < 20) ? 1'($urandom()) : 1'b0;
            run_left--;
            if ($urandom_range(0, 99) < 15)
               target = pick_target();
         end
         send_request(cmd, target, init_speed, init_accel);
         if ($urandom_range(0, 99) < 2)
            drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with the reset register values.
      // A plain step straight out of reset with a zero target sits in the
      // deadband; the load fields carry extremes that must be ignored.
      send_request(1'b0, 16'd0, 16'hFFFF, 16'sh7FFF);
      // Start from rest and ramp toward the full reference speed.
      send_request(1'b1, 16'd5632, 16'd0, 16'sd0);
      send_request(1'b0, 16'd5632, 16'd0, 16'sd0);
      send_request(1'b0, 16'd5632, 16'd0, 16'sd0);
      // Errors inside the deadband on both sides leave the acceleration alone.
      send_request(1'b1, 16'd5010, 16'd5000, 16'sd100);
      send_request(1'b1, 16'd4990, 16'd5000, -16'sd100);
      // Near the target from below and from above: ramp back toward zero.
      send_request(1'b1, 16'd5632, 16'd5600, 16'sd300);
      send_request(1'b1, 16'd5000, 16'd5100, -16'sd500);
      // A zero target never counts as near, so the far ramp slows the profile.
      send_request(1'b1, 16'd0, 16'd2560, 16'sd0);
      // Loaded accelerations beyond the limit snap to it on the first step.
      send_request(1'b1, 16'hFFFF, 16'd0, 16'sh7FFF);
      send_request(1'b1, 16'd0, 16'd5632, 16'sh8000);
      // Speed pushed over the ceiling, then driven below zero.
      send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'sh7FFF);
      send_request(1'b1, 16'd10, 16'd0, 16'sh8000);
      drain();

      // Zero ceiling and zero time step; the limits carry bit 15, which
      // the core must drop.
      configure(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_request(1'b1, 16'hFFFF, 16'd1000, 16'sd1000);
      send_request(1'b0, 16'hFFFF, 16'd0, 16'sd0);
      drain();

      // Full ceiling and time step with both limits at zero.
      configure(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
      send_request(1'b1, 16'd30000, 16'd1000, 16'sd200);
      send_request(1'b0, 16'd0, 16'd0, 16'sd0);
      send_request(1'b0, 16'd0, 16'd0, 16'sd0);
      drain();

      // Phase with nominal registers and no idling on either side.
      configure(CSR_DATA_W'(SPEED_CAP_RESET), CSR_DATA_W'(ACCEL_LIMIT_RESET),
                CSR_DATA_W'(JERK_LIMIT_RESET), CSR_DATA_W'(TIME_STEP_RESET));
      run_random(110);
      drain();

      // Phase with random registers; the sender is mostly idle.
      req_idle_pct = 78;
      configure(16'($urandom_range(1000, 65535)), 16'($urandom()), 16'($urandom()),
                16'($urandom_range(1, 4000)));
      run_random(110);
      drain();

      // Every register at its maximum while the receiver stalls most of the
      // time. The profile holds full speed long enough for the distance to
      // saturate; halfway through the sender waits for all responses.
      req_idle_pct = 0;
      rsp_stall_pct = 78;
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(1'b1, 16'hFFFF, 16'hFFFF, ACCEL_W'($urandom_range(0, 32767)));
      for (int i = 0; i < 263; i++) begin
         send_request(1'b0, 16'hFFFF, 16'($urandom()), 16'($urandom()));
         if (i == 130)
            drain();
      end
      drain();

      // Registers at extremes or random, light idling on both sides.
      req_idle_pct = 17;
      rsp_stall_pct = 17;
      configure(pick_extreme(0, 65535), pick_extreme(0, 65535), pick_extreme(0, 65535),
                pick_extreme(0, 65535));
      run_random(110);

      // Wait for the last responses, then allow a few more cycles so that
      // any stray response would still be seen.
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.failed())
         $display("FAIL");
      else
         $display("PASS");
      $finish;
   end

endmodule

// File: files.f
rtl/jlsp_pkg.sv
rtl/jlsp_ctrl.sv
rtl/jlsp_datapath.sv
rtl/jerk_limited_speed_profile_core.sv
dv/tb_top.sv
